// ----- rtl/ourx_pkg.sv -----
// Shared types and constants for the oversampled UART receiver.
package ourx_pkg;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_WAITH = 2'd3
  } line_phase_t;

  localparam int TICK_W   = 5;
  localparam int THRESH_W = 3;
  localparam int IDX_W    = 5;
  localparam int CFG_W    = 5;

  localparam logic [TICK_W-1:0]   SLOT_FIRST   = 5'b1_0000;
  localparam logic [TICK_W-1:0]   MASK_RESET   = 5'b0_1110;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 3'd2;
  localparam logic [7:0]          BIT_FIRST    = 8'h01;

  localparam logic REG_SAMPLE_MASK    = 1'b0;
  localparam logic REG_HIGH_THRESHOLD = 1'b1;

endpackage

// ----- rtl/oversampled_uart_receiver_top.sv -----
// Oversampled UART receiver: masked majority sampling, eight data bits, byte count limit.
//
//  channel  | direction | tdata fields (lowest bit first)
//  ---------+-----------+-------------------------------------------------------------
//  s_*      | in        | pin_level[0], restart[1], zero pad [7:2]
//  m_*      | out       | byte_valid[0], data_byte[8:1], byte_index[13:9],
//           |           | frame_error[14], buffer_full[15]
//  cfg_*    | in        | index 0 sample_mask[4:0], index 1 high_threshold[2:0]
//
// One sample per cycle while s_tready is high: each transfer is decoded in a
// single pass through the phase/tick logic and lands in the result register at
// the same edge, so the result is offered in the cycle after the input transfer.
// s_tready follows the result register: it is high whenever the register is
// empty or is being drained, so a stalled sink stops input only for as long
// as a result is held. rst (synchronous) restores the register reset values
// and empties the result register.
module oversampled_uart_receiver_top #(
  parameter int MAX_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // pin_level[0], restart[1], zero pad [7:2]
  input  logic [7:0]  s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // byte_valid[0], data_byte[8:1], byte_index[13:9], frame_error[14], buffer_full[15]
  output logic [15:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [ourx_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  // Configuration registers
  logic [ourx_pkg::TICK_W-1:0]   sample_mask;
  logic [ourx_pkg::THRESH_W-1:0] high_threshold;

  // Reception state
  ourx_pkg::line_phase_t         line_phase, line_phase_next;
  logic [ourx_pkg::TICK_W-1:0]   tick_slot, tick_slot_next;
  logic [7:0]                    bit_slot, bit_slot_next;
  logic [ourx_pkg::THRESH_W-1:0] high_count, high_count_next;
  logic [7:0]                    shift_byte, shift_byte_next;
  logic [CNT_W-1:0]              bytes_received, bytes_received_next;
  logic                          full_flag, full_flag_next;

  // Result fields of the current sample
  logic                        res_valid;
  logic [7:0]                  res_data;
  logic [ourx_pkg::IDX_W-1:0]  res_index;
  logic                        res_ferr;

  // Window evaluation helpers
  logic [ourx_pkg::THRESH_W-1:0] count_inc;
  logic [ourx_pkg::TICK_W-1:0]   tick_shift;
  logic                          bit_high;

  logic pin_level, restart, in_xfer;

  assign pin_level = s_tdata[0];
  assign restart   = s_tdata[1];
  assign s_tready  = !m_tvalid || m_tready;
  assign in_xfer   = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mask    <= ourx_pkg::MASK_RESET;
      high_threshold <= ourx_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ourx_pkg::REG_SAMPLE_MASK:    sample_mask    <= cfg_wdata;
        ourx_pkg::REG_HIGH_THRESHOLD: high_threshold <= cfg_wdata[ourx_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Count a high sample when its tick slot is selected by the mask, then advance the slot
  assign count_inc  = high_count + ourx_pkg::THRESH_W'(pin_level && |(tick_slot & sample_mask));
  assign tick_shift = tick_slot >> 1;
  assign bit_high   = count_inc >= high_threshold;

  // Next state and result for one sample
  always_comb begin
    line_phase_next     = line_phase;
    tick_slot_next      = tick_slot;
    bit_slot_next       = bit_slot;
    high_count_next     = high_count;
    shift_byte_next     = shift_byte;
    bytes_received_next = bytes_received;
    full_flag_next      = full_flag;
    res_valid           = 1'b0;
    res_data            = '0;
    res_index           = '0;
    res_ferr            = 1'b0;

    if (restart) begin
      // Reinitialise the reception state; the sample is dropped
      line_phase_next     = ourx_pkg::PH_HUNT;
      tick_slot_next      = ourx_pkg::SLOT_FIRST;
      bit_slot_next       = ourx_pkg::BIT_FIRST;
      high_count_next     = '0;
      shift_byte_next     = '0;
      bytes_received_next = '0;
      full_flag_next      = 1'b0;
    end else if (!full_flag) begin
      unique case (line_phase) inside
        ourx_pkg::PH_HUNT: begin
          // A low level opens a four-tick start window
          if (!pin_level) begin
            line_phase_next = ourx_pkg::PH_START;
            high_count_next = '0;
            tick_slot_next  = ourx_pkg::SLOT_FIRST >> 1;
          end
        end
        ourx_pkg::PH_WAITH: begin
          if (pin_level) line_phase_next = ourx_pkg::PH_HUNT;
        end
        ourx_pkg::PH_START, ourx_pkg::PH_DATA: begin
          high_count_next = count_inc;
          tick_slot_next  = tick_shift;
          if (tick_shift == '0) begin
            // End of a bit window: decide the bit
            tick_slot_next  = ourx_pkg::SLOT_FIRST;
            high_count_next = '0;
            if (line_phase == ourx_pkg::PH_START) begin
              if (!bit_high) begin
                line_phase_next = ourx_pkg::PH_DATA;
                shift_byte_next = '0;
                bit_slot_next   = ourx_pkg::BIT_FIRST;
              end else begin
                line_phase_next = ourx_pkg::PH_HUNT;
              end
            end else if (bit_slot != '0) begin
              if (bit_high) shift_byte_next = shift_byte | bit_slot;
              bit_slot_next = bit_slot << 1;
            end else begin
              // Stop bit
              if (bit_high) begin
                res_valid           = 1'b1;
                res_data            = shift_byte;
                res_index           = ourx_pkg::IDX_W'(bytes_received);
                bytes_received_next = bytes_received + CNT_W'(1);
                line_phase_next     = ourx_pkg::PH_HUNT;
              end else begin
                res_ferr        = 1'b1;
                line_phase_next = ourx_pkg::PH_WAITH;
              end
              if (bytes_received_next >= CNT_W'(MAX_BYTES)) full_flag_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State register: advance only on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase     <= ourx_pkg::PH_HUNT;
      tick_slot      <= ourx_pkg::SLOT_FIRST;
      bit_slot       <= ourx_pkg::BIT_FIRST;
      high_count     <= '0;
      shift_byte     <= '0;
      bytes_received <= '0;
      full_flag      <= 1'b0;
    end else if (in_xfer) begin
      line_phase     <= line_phase_next;
      tick_slot      <= tick_slot_next;
      bit_slot       <= bit_slot_next;
      high_count     <= high_count_next;
      shift_byte     <= shift_byte_next;
      bytes_received <= bytes_received_next;
      full_flag      <= full_flag_next;
    end
  end

  // Result register: load on input transfer, hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {full_flag_next, res_ferr, res_index, res_data, res_valid};
    end
  end

endmodule

// ----- rtl/ourx_checker.sv -----
// Port-level checks for the oversampled UART receiver, bound to the top level.
module ourx_checker (
  input logic        clk,
  input logic        rst,
  input logic [7:0]  s_tdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A byte and a frame error never complete on the same tick
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[14]))
    else $error("byte_valid and frame_error both set");

  // Without a byte, data and index read zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[13:1] == 13'd0)
    else $error("data or index set without byte_valid");

  // A restart transfer yields an all-zero result in the next cycle
  a_restart: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1] |=> m_tvalid && m_tdata == 16'd0)
    else $error("restart result not zero");

  // The result register is empty after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind oversampled_uart_receiver_top ourx_checker u_ourx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tdata  (s_tdata),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
